FILE: sv/selective_repeat_receive_window_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the selective-repeat receive window
// Clocked on clk, quiet while rst is high.
// ---------------------------------------------------------------------------
`ifndef SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH
`define SELECTIVE_REPEAT_RECEIVE_WINDOW_DEFINES_SVH

// same-cycle implication
`define SRRW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/srrw_pkg.sv
// ---------------------------------------------------------------------------
// srrw_pkg
// Types, widths and codes shared by the receive window modules.
// ---------------------------------------------------------------------------
package srrw_pkg;

  localparam int MAX_WINDOW = 8;
  localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

  localparam int SEQ_W      = 8;
  localparam int TAG_W      = 8;
  localparam int BYTES_W    = 8;
  localparam int QUEUE_W    = 17;
  localparam int LIMIT_W    = 16;
  localparam int WSIZE_W    = 4;
  localparam int UNACK_W    = 8;
  localparam int MOD_CNT_W  = $clog2(SEQ_W);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam int IN_DATA_W  = 32;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  localparam logic [QUEUE_W-1:0] QUEUED_MAX   = '1;
  localparam logic [UNACK_W-1:0] UNACK_MAX    = '1;
  localparam logic [UNACK_W-1:0] ACK_BURST    = UNACK_W'(4);
  localparam logic [WSIZE_W-1:0] WINDOW_RESET = WSIZE_W'(4);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(2048);

  typedef enum logic [1:0] {
    ACT_INFO    = 2'd0,
    ACT_DRAIN   = 2'd1,
    ACT_SENT    = 2'd2,
    ACT_UNCHOKE = 2'd3
  } action_t;

  typedef enum logic {
    KIND_DELIVER = 1'b0,
    KIND_STATUS  = 1'b1
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 1'b0,
    REG_LIMIT  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_CHECK,
    ST_DRAIN,
    ST_POST,
    ST_STATUS
  } state_t;

  // input item, seq in the lowest bits
  typedef struct packed {
    logic [6:0]         pad;
    logic               tx_window_empty;
    logic [BYTES_W-1:0] byte_count;
    logic [TAG_W-1:0]   buffer_tag;
    logic [SEQ_W-1:0]   seq;
  } in_item_t;

  // result item, out_tag in the lowest bits
  typedef struct packed {
    logic [2:0]       pad;
    logic             choked_flag;
    logic             discarded;
    logic             ack_now;
    logic             restart_ack_timer;
    logic             send_nak;
    logic [SEQ_W-1:0] out_seq;
    logic [TAG_W-1:0] out_tag;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic mod_step;
    logic check;
    logic deliver;
    logic post;
    logic status;
  } ctrl_cmd_t;

  typedef struct packed {
    logic info_go;
    logic mod_last;
    logic head_full;
    logic newdata;
    logic out_free;
  } dp_stat_t;

endpackage

FILE: sv/selective_repeat_receive_window.sv
// ---------------------------------------------------------------------------
// selective_repeat_receive_window
// Receive side of an 8-bit sequence-numbered selective-repeat ARQ window.
// ---------------------------------------------------------------------------
// Each input item is an info frame or a bookkeeping event (consumer drain,
// own frame sent, choke release). An info frame inside the window that is
// not already held goes into slot seq mod window; every complete in-order
// run from the expected sequence number then leaves as one delivery item
// per frame, and each input ends with one status item (tlast high) carrying
// NAK / ack-timer / ack-now / discard flags and the choke state. One item is
// worked at a time. The bit-serial remainder unit finds seq mod window and
// expected mod window, one dividend bit per cycle. Output stalls hold up the
// delivery and status items. The input side is ready again while the final
// status item still waits in the output register. The user must write
// window_size and queue_limit only while idle; the block itself does not
// enforce it.
// ---------------------------------------------------------------------------
module selective_repeat_receive_window (
  input  logic                                clk,
  input  logic                                rst,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]      cfg_index,  // 0 window_size, 1 queue_limit
  input  logic [srrw_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input items
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // [7:0] seq, [15:8] buffer_tag, [23:16] byte_count, [24] tx_window_empty
  input  logic [srrw_pkg::IN_DATA_W-1:0]      s_tdata,
  // [1:0] action
  input  logic [srrw_pkg::IN_USER_W-1:0]      s_tuser,
  // result items
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [7:0] out_tag, [15:8] out_seq, [16] send_nak, [17] restart_ack_timer,
  // [18] ack_now, [19] discarded, [20] choked_flag
  output logic [srrw_pkg::OUT_DATA_W-1:0]     m_tdata,
  // [0] kind: 0 delivery, 1 status
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import srrw_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: owns the handshake on the input side
  srrw_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // window state, slot store and output register
  srrw_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

FILE: sv/srrw_ctrl.sv
// ---------------------------------------------------------------------------
// srrw_ctrl
// Sequencer: accept, remainder steps, window check, drain, post, status.
// ---------------------------------------------------------------------------
module srrw_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  srrw_pkg::dp_stat_t stat,
  output srrw_pkg::ctrl_cmd_t cmd
);
  import srrw_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    s_tready   = 1'b0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = stat.info_go ? ST_MOD : ST_STATUS;
        end
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.check  = 1'b1;
        state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (stat.head_full) begin
          cmd.deliver = stat.out_free;
        end else if (stat.newdata) begin
          state_next = ST_POST;
        end else begin
          state_next = ST_STATUS;
        end
      end
      ST_POST: begin
        cmd.post   = 1'b1;
        state_next = ST_STATUS;
      end
      ST_STATUS: begin
        if (stat.out_free) begin
          cmd.status = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/srrw_dp.sv
// ---------------------------------------------------------------------------
// srrw_dp
// Window state, slot store, remainder unit, queue accounting, output register.
// ---------------------------------------------------------------------------
module srrw_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  srrw_pkg::ctrl_cmd_t                 cmd,
  output srrw_pkg::dp_stat_t                  stat,
  input  logic                                cfg_we,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [srrw_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [srrw_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [srrw_pkg::IN_USER_W-1:0]      s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [srrw_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                m_tuser,
  output logic                                m_tlast
);
  import srrw_pkg::*;

  // one restoring-remainder step: shift in one dividend bit, subtract if it fits
  function automatic logic [WIN_W-1:0] rem_step(input logic [WIN_W-1:0] r,
                                                 input logic b,
                                                 input logic [WIN_W-1:0] d);
    logic [WIN_W:0] t;
    logic [WIN_W:0] s;
    t = {r, b};
    s = t - {1'b0, d};
    return (t >= {1'b0, d}) ? s[WIN_W-1:0] : t[WIN_W-1:0];
  endfunction

  // config
  logic [WSIZE_W-1:0]   window_size;
  logic [LIMIT_W-1:0]   queue_limit;

  // window state
  logic [SEQ_W-1:0]     expected_seq;
  logic                 nak_pending;
  logic [MAX_WINDOW-1:0] slot_full;
  logic [TAG_W-1:0]     slot_tag   [MAX_WINDOW];
  logic [BYTES_W-1:0]   slot_bytes [MAX_WINDOW];
  logic [QUEUE_W-1:0]   queued_bytes;
  logic                 choked;
  logic [UNACK_W-1:0]   unacked_count;
  logic                 newdata;

  // current item
  logic [SEQ_W-1:0]     seq_q;
  logic [TAG_W-1:0]     tag_q;
  logic [BYTES_W-1:0]   bytes_q;
  logic                 txempty_q;

  // remainder unit, two lanes sharing the divisor
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [WIN_W-1:0]     rem_seq;
  logic [WIN_W-1:0]     rem_exp;

  logic [SLOT_W-1:0]    head_slot;
  logic                 f_nak;
  logic                 f_rst;
  logic                 f_ack;
  logic                 f_disc;
  logic [SEQ_W-1:0]     nak_seq;

  in_item_t             in_d;
  action_t              act;
  out_item_t            o_next;
  logic [7:0]           ws_wide;
  logic [WIN_W-1:0]     w;
  logic [SEQ_W-1:0]     diff;
  logic [SEQ_W-1:0]     rep_diff;
  logic                 in_win;
  logic                 is_rep;
  logic [SLOT_W-1:0]    seq_slot;
  logic                 take;
  logic [QUEUE_W:0]     q_add;
  logic [QUEUE_W-1:0]   q_add_sat;
  logic [WIN_W-1:0]     head_p1;
  logic [SLOT_W-1:0]    head_adv;
  logic [UNACK_W-1:0]   unacked_inc;

  assign in_d = in_item_t'(s_tdata);
  assign act  = action_t'(s_tuser);

  // effective window: 0 acts as 1, clamp at the slot count
  always_comb begin
    ws_wide = {4'b0, window_size};
    if (window_size == '0) begin
      w = WIN_W'(1);
    end else if (ws_wide > 8'(MAX_WINDOW)) begin
      w = WIN_W'(MAX_WINDOW);
    end else begin
      w = ws_wide[WIN_W-1:0];
    end
  end

  assign diff     = seq_q - expected_seq;
  assign rep_diff = seq_q + SEQ_W'(w) - expected_seq;
  assign in_win   = diff < SEQ_W'(w);
  assign is_rep   = rep_diff < SEQ_W'(w);
  assign seq_slot = rem_seq[SLOT_W-1:0];
  assign take     = in_win && !slot_full[seq_slot];

  assign q_add     = {1'b0, queued_bytes} + (QUEUE_W + 1)'(slot_bytes[head_slot]);
  assign q_add_sat = q_add[QUEUE_W] ? QUEUED_MAX : q_add[QUEUE_W-1:0];

  // expected%w follows expected+1, except at the 8-bit wrap where it restarts
  assign head_p1  = WIN_W'(head_slot) + WIN_W'(1);
  assign head_adv = (expected_seq == '1 || head_p1 == w) ? '0 : head_p1[SLOT_W-1:0];

  assign unacked_inc = (unacked_count == UNACK_MAX) ? unacked_count
                                                    : unacked_count + UNACK_W'(1);

  assign stat.info_go   = (act == ACT_INFO) && !choked;
  assign stat.mod_last  = (mod_cnt == '0);
  assign stat.head_full = slot_full[head_slot];
  assign stat.newdata   = newdata;
  assign stat.out_free  = !m_tvalid || m_tready;

  always_comb begin
    o_next             = '0;
    o_next.choked_flag = choked;
    if (cmd.deliver) begin
      o_next.out_tag = slot_tag[head_slot];
      o_next.out_seq = expected_seq;
    end else begin
      o_next.out_tag           = f_disc ? tag_q : '0;
      o_next.out_seq           = f_nak ? nak_seq : '0;
      o_next.send_nak          = f_nak;
      o_next.restart_ack_timer = f_rst;
      o_next.ack_now           = f_ack;
      o_next.discarded         = f_disc;
    end
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (rst) begin
      window_size   <= WINDOW_RESET;
      queue_limit   <= LIMIT_RESET;
      expected_seq  <= '0;
      nak_pending   <= 1'b0;
      slot_full     <= '0;
      queued_bytes  <= '0;
      choked        <= 1'b0;
      unacked_count <= '0;
      newdata       <= 1'b0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (reg_idx_t'(cfg_index))
          REG_WINDOW: window_size <= cfg_data[WSIZE_W-1:0];
          REG_LIMIT:  queue_limit <= cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (cmd.accept) begin
        newdata <= 1'b0;
        case (act)
          ACT_DRAIN: begin
            queued_bytes <= (queued_bytes > QUEUE_W'(in_d.byte_count))
                          ? queued_bytes - QUEUE_W'(in_d.byte_count) : '0;
          end
          ACT_SENT:    unacked_count <= '0;
          ACT_UNCHOKE: choked <= 1'b0;
          default: ;
        endcase
      end
      if (cmd.check) begin
        if (seq_q != expected_seq && !nak_pending && !is_rep) begin
          nak_pending <= 1'b1;
        end
        if (take) begin
          slot_full[seq_slot] <= 1'b1;
        end
      end
      if (cmd.deliver) begin
        slot_full[head_slot] <= 1'b0;
        queued_bytes         <= q_add_sat;
        expected_seq         <= expected_seq + SEQ_W'(1);
        newdata              <= 1'b1;
      end
      if (cmd.post) begin
        nak_pending   <= 1'b0;
        unacked_count <= unacked_inc;
        if (queued_bytes > QUEUE_W'(queue_limit)) begin
          choked <= 1'b1;
        end
      end
      if (cmd.deliver || cmd.status) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      seq_q     <= in_d.seq;
      tag_q     <= in_d.buffer_tag;
      bytes_q   <= in_d.byte_count;
      txempty_q <= in_d.tx_window_empty;
      mod_cnt   <= MOD_CNT_W'(SEQ_W - 1);
      rem_seq   <= '0;
      rem_exp   <= '0;
      f_nak     <= 1'b0;
      f_ack     <= 1'b0;
      // a choked receiver drops info frames and rearms the ack timer
      f_rst     <= (act == ACT_INFO) && choked;
      f_disc    <= (act == ACT_INFO) && choked;
    end
    if (cmd.mod_step) begin
      mod_cnt <= mod_cnt - MOD_CNT_W'(1);
      rem_seq <= rem_step(rem_seq, seq_q[mod_cnt], w);
      rem_exp <= rem_step(rem_exp, expected_seq[mod_cnt], w);
    end
    if (cmd.check) begin
      head_slot <= rem_exp[SLOT_W-1:0];
      if (seq_q != expected_seq && !nak_pending) begin
        if (is_rep) begin
          f_rst <= 1'b1;
        end else begin
          f_nak   <= 1'b1;
          nak_seq <= expected_seq;
        end
      end
      if (take) begin
        slot_tag[seq_slot]   <= tag_q;
        slot_bytes[seq_slot] <= bytes_q;
      end else begin
        f_disc <= 1'b1;
      end
    end
    if (cmd.deliver) begin
      head_slot <= head_adv;
    end
    if (cmd.post) begin
      if (queued_bytes > QUEUE_W'(queue_limit)) begin
        f_ack <= 1'b1;
      end else if (txempty_q && unacked_inc >= ACK_BURST) begin
        f_ack <= 1'b1;
      end else begin
        f_rst <= 1'b1;
      end
    end
    if (cmd.deliver || cmd.status) begin
      m_tdata <= o_next;
      m_tuser <= cmd.status ? KIND_STATUS : KIND_DELIVER;
      m_tlast <= cmd.status;
    end
  end

endmodule

FILE: sv/srrw_checker.sv
// ---------------------------------------------------------------------------
// srrw_checker
// Port-level checks on the receive window, bound to the top level.
// ---------------------------------------------------------------------------
`include "selective_repeat_receive_window_defines.svh"

module srrw_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [srrw_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                            m_tuser,
  input logic                            m_tlast
);
  import srrw_pkg::*;

  out_item_t o;
  logic      o_flags;

  assign o       = out_item_t'(m_tdata);
  assign o_flags = o.send_nak | o.restart_ack_timer | o.ack_now | o.discarded;

  // stalled result holds
  `SRRW_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed under stall")

  // only the status item closes an input
  `SRRW_ASSERT_IMP(a_last_kind, m_tvalid, m_tlast == (m_tuser == KIND_STATUS), "tlast and kind disagree")

  // deliveries carry no action flags
  `SRRW_ASSERT_IMP(a_deliver_clean, m_tvalid && m_tuser == KIND_DELIVER, !o_flags, "flags on delivery")

  // one item at a time: no accept on the cycle after an accept
  `SRRW_ASSERT_NXT(a_one_item, s_tvalid && s_tready, !s_tready, "back-to-back accept")

endmodule

bind selective_repeat_receive_window srrw_checker u_srrw_checker (.*);

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives info frames and bookkeeping events into the receive window and
// checks every delivery and status item against a cycle-free predictor.
// ---------------------------------------------------------------------------
// The sender offers items in bursts with random gaps. The receiver stalls
// in a changing random pattern and once holds off for a long stretch so
// the block backs up. Most info frames come in window-sized rounds built
// around the predicted expected sequence number, in order or shuffled, with some
// frames lost, so NAKs, repeats, held slots and multi-frame runs all occur.
// ---------------------------------------------------------------------------
module testbench;
  import srrw_pkg::*;

  localparam int HOLD_CYCLES = 400;

  // one predicted result item
  typedef struct {
    kind_t      kind;
    logic [7:0] tag;
    logic [7:0] seq;
    logic       nak;
    logic       restart;
    logic       ack;
    logic       disc;
    logic       choke;
    logic       last;
  } rx_result_t;

  // Predicts the receive window: own copy of state and registers, plus the
  // queue of result items still owed by the block.
  class rx_window_tracker;
    logic [3:0]  window_reg;
    logic [15:0] limit_reg;
    logic [7:0]  exp_seq;
    logic        nak_pending;
    logic        slot_full[MAX_WINDOW];
    logic [7:0]  slot_tag[MAX_WINDOW];
    logic [7:0]  slot_bytes[MAX_WINDOW];
    logic [16:0] queued;
    logic        choked;
    logic [7:0]  unacked;
    rx_result_t  due_results[$];
    int          errors;

    function new();
      window_reg  = WINDOW_RESET;
      limit_reg   = LIMIT_RESET;
      exp_seq     = '0;
      nak_pending = 1'b0;
      queued      = '0;
      choked      = 1'b0;
      unacked     = '0;
      errors      = 0;
      for (int i = 0; i < MAX_WINDOW; i++) begin
        slot_full[i]  = 1'b0;
        slot_tag[i]   = '0;
        slot_bytes[i] = '0;
      end
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] val);
      if (idx == REG_WINDOW) window_reg = val[3:0];
      else limit_reg = val;
    endfunction

    // 0 behaves as 1, anything above the slot count as the slot count
    function int unsigned live_window();
      if (window_reg == 0) return 1;
      if (window_reg > MAX_WINDOW) return MAX_WINDOW;
      return window_reg;
    endfunction

    function void accept_item(action_t act, logic [7:0] sq, logic [7:0] tg,
                              logic [7:0] bc, logic txe);
      rx_result_t  r;
      int unsigned w, slot, n;
      logic        nak, restart, ack, disc, newdata;
      logic [7:0]  nak_seq;
      logic [17:0] q_sum;
      nak = 0; restart = 0; ack = 0; disc = 0; newdata = 0;
      nak_seq = '0;
      n = 0;
      case (act)
        ACT_DRAIN:   queued = (queued > bc) ? queued - bc : '0;
        ACT_SENT:    unacked = '0;
        ACT_UNCHOKE: choked = 1'b0;
        default: begin
          if (choked) begin
            // dropped while choked, only the timer restarts
            restart = 1'b1;
            disc    = 1'b1;
          end else begin
            w    = live_window();
            slot = sq % w;
            if (sq != exp_seq && !nak_pending) begin
              // repeat from the last window vs. a real gap
              if (8'(sq + 8'(w) - exp_seq) < w) restart = 1'b1;
              else begin
                nak         = 1'b1;
                nak_seq     = exp_seq;
                nak_pending = 1'b1;
              end
            end
            if (8'(sq - exp_seq) < w && !slot_full[slot]) begin
              slot_full[slot]  = 1'b1;
              slot_tag[slot]   = tg;
              slot_bytes[slot] = bc;
              slot = exp_seq % w;
              // hand out the in-order run; choke not yet updated here
              while (slot_full[slot] && n < MAX_WINDOW) begin
                newdata         = 1'b1;
                slot_full[slot] = 1'b0;
                // one bit of headroom so the sum cannot wrap before the clamp
                q_sum  = 18'(queued) + 18'(slot_bytes[slot]);
                queued = (q_sum > 18'(QUEUED_MAX)) ? QUEUED_MAX : q_sum[16:0];
                r = '{KIND_DELIVER, slot_tag[slot], exp_seq, 0, 0, 0, 0, choked, 0};
                due_results.push_back(r);
                n++;
                exp_seq = exp_seq + 8'd1;
                slot    = exp_seq % w;
              end
              if (newdata) begin
                nak_pending = 1'b0;
                if (unacked != UNACK_MAX) unacked = unacked + 8'd1;
                if (queued > limit_reg) begin
                  choked = 1'b1;
                  ack    = 1'b1;
                end else if (txe && unacked >= ACK_BURST) ack = 1'b1;
                else restart = 1'b1;
              end
            end else disc = 1'b1;
          end
        end
      endcase
      r = '{KIND_STATUS, disc ? tg : 8'd0, nak ? nak_seq : 8'd0,
            nak, restart, ack, disc, choked, 1'b1};
      due_results.push_back(r);
    endfunction

    function void field_ok(string name, logic [7:0] want, logic [7:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0h, got %0h", name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] data, logic user, logic tl);
      out_item_t  got;
      rx_result_t e;
      got = out_item_t'(data);
      if (due_results.size() == 0) begin
        $error("result item with nothing expected: tdata %h tuser %b", data, user);
        errors++;
        return;
      end
      e = due_results.pop_front();
      field_ok("kind", e.kind, user);
      field_ok("out_tag", e.tag, got.out_tag);
      field_ok("out_seq", e.seq, got.out_seq);
      field_ok("send_nak", e.nak, got.send_nak);
      field_ok("restart_ack_timer", e.restart, got.restart_ack_timer);
      field_ok("ack_now", e.ack, got.ack_now);
      field_ok("discarded", e.disc, got.discarded);
      field_ok("choked_flag", e.choke, got.choked_flag);
      field_ok("last", e.last, tl);
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;   // [7:0] seq, [15:8] tag, [23:16] bytes, [24] txe
  logic [IN_USER_W-1:0]  s_tuser = '0;   // [1:0] action
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;        // [7:0] tag, [15:8] seq, [20:16] flags
  logic                  m_tuser;        // [0] kind
  logic                  m_tlast;

  rx_window_tracker tracker = new();

  logic hold_req = 1'b0;   // asks the receiver for one long hold-off
  int   sent_count = 0;
  int   burst_left = 1;

  selective_repeat_receive_window dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop in case the block hangs
  initial begin
    #3_000_000;
    $display("Some tests failed");
    $finish;
  end

  // receiver: picks a new random stall mode whenever the current one runs out
  initial begin
    int   mode;
    int   mode_left;
    logic rdy;
    mode_left = 0;
    mode      = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 80);
      end
      mode_left--;
      case (mode)
        0:       rdy = 1'b1;
        1:       rdy = 1'($urandom_range(0, 1));
        2:       rdy = ($urandom_range(0, 3) == 0);
        default: rdy = ($urandom_range(0, 9) != 0);
      endcase
      m_tready <= rdy;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) tracker.check_result(m_tdata, m_tuser, m_tlast);
  end

  // valid is lowered only by the gap and settle tasks
  task automatic idle_gap(int n);
    @(negedge clk);
    s_tvalid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic send_item(action_t act, logic [7:0] sq, logic [7:0] tg,
                           logic [7:0] bc, logic txe);
    in_item_t it;
    it = '{pad: '0, tx_window_empty: txe, byte_count: bc, buffer_tag: tg, seq: sq};
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= it;
    do @(posedge clk); while (!s_tready);
    tracker.accept_item(act, sq, tg, bc, txe);
    sent_count++;
    burst_left--;
    if (burst_left <= 0) begin
      idle_gap($urandom_range(1, 8));
      // now and then a long stretch with no gaps
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  // stop offering and wait until every owed result has come out
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (tracker.due_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] win, logic [15:0] lim);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    tracker.write_reg(REG_WINDOW, win);
    @(negedge clk);
    cfg_index <= REG_LIMIT;
    cfg_data  <= lim;
    @(posedge clk);
    tracker.write_reg(REG_LIMIT, lim);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one window's worth of frames from the expected number, some lost,
  // in order or shuffled
  task automatic send_window_round();
    int unsigned w, j, t;
    int unsigned order[MAX_WINDOW];
    logic [7:0]  base;
    w    = tracker.live_window();
    base = tracker.exp_seq;
    for (int i = 0; i < w; i++) order[i] = i;
    if ($urandom_range(0, 1) == 0) begin
      for (int i = w - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = order[i];
        order[i] = order[j];
        order[j] = t;
      end
    end
    for (int i = 0; i < w; i++) begin
      if ($urandom_range(0, 7) != 0)
        send_item(ACT_INFO, 8'(base + order[i]), 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  task automatic run_phase(logic [15:0] win, logic [15:0] lim, int n, bit squeeze);
    int          target, pick;
    int unsigned w;
    bit          mid_done;
    settle();
    set_config(win, lim);
    target   = sent_count + n;
    mid_done = 1'b0;
    if (squeeze) hold_req = 1'b1;   // receiver backs off while we keep sending
    while (sent_count < target) begin
      // rounds add several items at once, so catch the halfway point once
      if (squeeze && !mid_done && sent_count >= target - n / 2) begin
        settle();
        mid_done = 1'b1;
      end
      pick = $urandom_range(0, 99);
      w    = tracker.live_window();
      if (tracker.choked && $urandom_range(0, 2) != 0) begin
        send_item(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
        send_item(ACT_UNCHOKE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      end else if (pick < 70) send_window_round();
      else if (pick < 78)
        send_item(ACT_DRAIN, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 84)
        send_item(ACT_SENT, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 88)
        send_item(ACT_UNCHOKE, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
      else if (pick < 94)   // repeat from the previous window
        send_item(ACT_INFO, 8'(tracker.exp_seq - $urandom_range(1, w)), 8'($urandom),
                  8'($urandom), 1'($urandom));
      else                  // anywhere in sequence space
        send_item(ACT_INFO, 8'($urandom), 8'($urandom), 8'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed, reset settings: window 4, limit 2048
    send_item(ACT_INFO, 8'd0, 8'h00, 8'hFF, 1'b0);    // in order, delivered
    send_item(ACT_INFO, 8'd2, 8'hFF, 8'h00, 1'b0);    // gap: NAK, held
    send_item(ACT_INFO, 8'd3, 8'h5A, 8'h10, 1'b1);    // held, NAK already out
    send_item(ACT_INFO, 8'd2, 8'hA5, 8'h10, 1'b1);    // already held: dropped
    send_item(ACT_INFO, 8'd1, 8'h11, 8'h20, 1'b0);    // fills gap: run of three
    send_item(ACT_INFO, 8'd0, 8'h22, 8'h20, 1'b1);    // repeat of last window
    send_item(ACT_INFO, 8'd200, 8'h33, 8'h20, 1'b1);  // far outside: NAK, dropped
    send_item(ACT_INFO, 8'd4, 8'h44, 8'h01, 1'b1);
    send_item(ACT_SENT, 8'hFF, 8'hFF, 8'hFF, 1'b1);   // clears unacked count
    for (int i = 5; i <= 8; i++)                      // fourth one asks for an ack
      send_item(ACT_INFO, 8'(i), 8'(i * 16), 8'h02, 1'b1);
    send_item(ACT_DRAIN, 8'h00, 8'h00, 8'h55, 1'b0);
    send_item(ACT_UNCHOKE, 8'h00, 8'h00, 8'h00, 1'b0);
    send_item(ACT_INFO, 8'd255, 8'hFF, 8'hFF, 1'b1);  // top of sequence space

    // directed choke handling with a zero limit
    settle();
    set_config(16'd4, 16'd0);
    send_item(ACT_INFO, 8'd9, 8'h99, 8'h01, 1'b0);    // delivered, chokes
    send_item(ACT_INFO, 8'd10, 8'hAA, 8'h01, 1'b1);   // choked: dropped
    send_item(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF, 1'b1);  // drains to zero
    send_item(ACT_UNCHOKE, 8'hFF, 8'hFF, 8'hFF, 1'b1);
    send_item(ACT_INFO, 8'd10, 8'hBB, 8'h00, 1'b1);   // zero bytes: no choke

    // random phases across window and limit extremes
    run_phase(16'd8, 16'hFFFF, 35, 1'b1);
    run_phase(16'd1, 16'd0, 20, 1'b0);
    run_phase(16'd15, 16'($urandom_range(300, 1500)), 25, 1'b0);
    run_phase({12'hABC, 4'd0}, 16'($urandom), 20, 1'b0);
    run_phase(16'($urandom_range(1, MAX_WINDOW)), 16'($urandom_range(200, 3000)), 35, 1'b0);

    settle();
    if (tracker.errors == 0 && tracker.due_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: selective_repeat_receive_window.f
+incdir+sv
sv/srrw_pkg.sv
sv/srrw_ctrl.sv
sv/srrw_dp.sv
sv/selective_repeat_receive_window.sv
sv/srrw_checker.sv
dv/testbench.sv
